@@ rtl/swr_pkg.sv @@
// swr_pkg: shared widths, register indexes and the draw descriptor for the
// sample_without_replacement block
// no dependencies
`default_nettype none

package swr_pkg;

    localparam int WORD_W    = 32;
    localparam int SPAN_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int EPOCH_W   = 8;
    localparam int DIV_STEPS = 32;
    localparam int STEP_W    = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd2;

    // one classified draw, front to back
    typedef struct packed {
        logic [WORD_W-1:0] random_word;
        logic [SPAN_W-1:0] position;
        logic [SPAN_W-1:0] divisor;
        logic              last;
        logic              exhausted;
    } draw_item_t;

    // back to front status
    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

`default_nettype wire

@@ rtl/swr_front.sv @@
// swr_front: accepts random words, tracks the draw position and classifies
// each beat as a draw or an exhausted beat
// depends on swr_pkg
`default_nettype none

module swr_front #(
    parameter int RANGE_DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [swr_pkg::WORD_W-1:0]  random_word,
    input  logic [swr_pkg::SPAN_W-1:0]  span,
    input  logic [swr_pkg::SPAN_W-1:0]  sample_count,
    input  swr_pkg::back_status_t       status,
    input  logic                        push_ready,
    output logic                        push_valid,
    output swr_pkg::draw_item_t         push_item
);
    import swr_pkg::*;

    localparam int DW = $clog2(RANGE_DEPTH + 1);
    localparam int CW = (DW > SPAN_W) ? DW : SPAN_W;

    logic [SPAN_W-1:0] position_reg;
    logic [SPAN_W-1:0] position_next;
    logic [CW-1:0]     span_wide;
    logic [CW-1:0]     depth_wide;
    logic [CW-1:0]     eff_wide;
    logic [SPAN_W-1:0] eff_span;
    logic              exh;
    logic              count_hit;
    logic              last_draw;
    logic              accept;

    // span above table depth is clamped to the depth
    assign span_wide  = CW'(span);
    assign depth_wide = CW'(RANGE_DEPTH);
    assign eff_wide   = (span_wide > depth_wide) ? depth_wide : span_wide;
    assign eff_span   = eff_wide[SPAN_W-1:0];

    assign exh       = (position_reg >= eff_span);
    assign count_hit = ((SPAN_W + 1)'(position_reg) + (SPAN_W + 1)'(1))
                       == (SPAN_W + 1)'(sample_count);
    assign last_draw = !exh && count_hit;

    assign accept     = item_valid && push_ready && !status.clearing;
    assign item_stall = !(push_ready && !status.clearing);
    assign push_valid = accept;

    always_comb
    begin
        push_item.random_word = random_word;
        push_item.position    = position_reg;
        push_item.divisor     = eff_span - position_reg;
        push_item.last        = last_draw;
        push_item.exhausted   = exh;
    end

    always_comb
    begin
        position_next = position_reg;
        if (accept)
        begin
            if (exh || last_draw)
                position_next = '0;
            else
                position_next = position_reg + SPAN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            position_reg <= '0;
        else
            position_reg <= position_next;
    end

endmodule

`default_nettype wire

@@ rtl/swr_queue.sv @@
// swr_queue: two-entry queue of classified draws between front and back
// depends on swr_pkg
`default_nettype none

module swr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  swr_pkg::draw_item_t push_item,
    output logic                push_ready,
    output logic                pop_valid,
    input  logic                pop_ready,
    output swr_pkg::draw_item_t pop_item
);
    import swr_pkg::*;

    draw_item_t  entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/swr_back.sv @@
// swr_back: bit-serial modulo, epoch-tagged slot table and result register
// depends on swr_pkg
`default_nettype none

module swr_back #(
    parameter int RANGE_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  swr_pkg::draw_item_t               pop_item,
    input  logic signed [swr_pkg::WORD_W-1:0] low_bound,
    output swr_pkg::back_status_t             status,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [swr_pkg::WORD_W-1:0] drawn_value,
    output logic                              last,
    output logic                              exhausted
);
    import swr_pkg::*;

    localparam int IDX_W = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
    localparam int AW    = (IDX_W > SPAN_W) ? IDX_W : SPAN_W;
    localparam int ENT_W = EPOCH_W + IDX_W;
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(RANGE_DEPTH - 1);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_RDJ   = 7'b0001000,
        ST_RDI   = 7'b0010000,
        ST_WR    = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } back_state_t;

    back_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [SPAN_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [SPAN_W-1:0]  pos_reg, pos_next;
    logic [SPAN_W-1:0]  div_reg, div_next;
    logic               last_item_reg, last_item_next;
    logic               exh_item_reg, exh_item_next;
    logic [SPAN_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]   vj_reg, vj_next;
    logic [WORD_W-1:0]  res_value_reg, res_value_next;

    logic               result_valid_reg, result_valid_next;
    logic [WORD_W-1:0]  drawn_value_reg, drawn_value_next;
    logic               last_reg, last_next;
    logic               exhausted_reg, exhausted_next;

    logic [ENT_W-1:0]   mem [RANGE_DEPTH];
    logic [ENT_W-1:0]   rdata_reg;
    logic [IDX_W-1:0]   raddr;
    logic [IDX_W-1:0]   waddr;
    logic [ENT_W-1:0]   wdata;
    logic               we;

    logic [SPAN_W:0]    div_trial;
    logic [SPAN_W:0]    div_sub;
    logic               div_ge;
    logic [SPAN_W-1:0]  j_sum;
    logic [AW-1:0]      j_sum_wide;
    logic [AW-1:0]      j_wide;
    logic [AW-1:0]      pos_wide;
    logic [IDX_W-1:0]   j_sum_addr;
    logic [IDX_W-1:0]   j_addr;
    logic [IDX_W-1:0]   pos_addr;
    logic               entry_hit;
    logic [IDX_W-1:0]   entry_val;
    logic               out_free;

    // restoring remainder step, one quotient bit a cycle
    assign div_trial = {rem_reg, word_reg[WORD_W-1]};
    assign div_sub   = div_trial - {1'b0, div_reg};
    assign div_ge    = (div_trial >= {1'b0, div_reg});

    assign j_sum      = rem_reg + pos_reg;
    assign j_sum_wide = AW'(j_sum);
    assign j_wide     = AW'(j_reg);
    assign pos_wide   = AW'(pos_reg);
    assign j_sum_addr = j_sum_wide[IDX_W-1:0];
    assign j_addr     = j_wide[IDX_W-1:0];
    assign pos_addr   = pos_wide[IDX_W-1:0];

    // entry counts as written only when tagged with the current epoch
    assign entry_hit = (rdata_reg[ENT_W-1 -: EPOCH_W] == epoch_reg);
    assign entry_val = rdata_reg[IDX_W-1:0];

    assign out_free        = !result_valid_reg || !result_stall;
    assign pop_ready       = (state_reg == ST_IDLE);
    assign status.clearing = (state_reg == ST_CLEAR);

    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        epoch_next        = epoch_reg;
        word_next         = word_reg;
        rem_next          = rem_reg;
        step_next         = step_reg;
        pos_next          = pos_reg;
        div_next          = div_reg;
        last_item_next    = last_item_reg;
        exh_item_next     = exh_item_reg;
        j_next            = j_reg;
        vj_next           = vj_reg;
        res_value_next    = res_value_reg;
        result_valid_next = result_valid_reg && result_stall;
        drawn_value_next  = drawn_value_reg;
        last_next         = last_reg;
        exhausted_next    = exhausted_reg;
        raddr             = '0;
        waddr             = '0;
        wdata             = '0;
        we                = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                we            = 1'b1;
                waddr         = clr_addr_reg;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_addr_next = '0;
                    epoch_next    = EPOCH_W'(1);
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    word_next      = pop_item.random_word;
                    pos_next       = pop_item.position;
                    div_next       = pop_item.divisor;
                    last_item_next = pop_item.last;
                    exh_item_next  = pop_item.exhausted;
                    rem_next       = '0;
                    step_next      = '0;
                    state_next     = pop_item.exhausted ? ST_EMIT : ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = div_ge ? div_sub[SPAN_W-1:0] : div_trial[SPAN_W-1:0];
                word_next = word_reg << 1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_RDJ;
            end
            ST_RDJ:
            begin
                raddr      = j_sum_addr;
                j_next     = j_sum;
                state_next = ST_RDI;
            end
            ST_RDI:
            begin
                vj_next    = entry_hit ? entry_val : j_addr;
                raddr      = pos_addr;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                we             = 1'b1;
                waddr          = j_addr;
                wdata          = {epoch_reg, entry_hit ? entry_val : pos_addr};
                res_value_next = low_bound + WORD_W'(vj_reg);
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    drawn_value_next  = exh_item_reg ? '0 : res_value_reg;
                    last_next         = last_item_reg;
                    exhausted_next    = exh_item_reg;
                    state_next        = ST_IDLE;
                    // sample ends: move to a fresh epoch, sweep when tags run out
                    if (last_item_reg || exh_item_reg)
                    begin
                        if (epoch_reg == '1)
                        begin
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EPOCH_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next    = ST_CLEAR;
                clr_addr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        rem_reg       <= rem_next;
        step_reg      <= step_next;
        pos_reg       <= pos_next;
        div_reg       <= div_next;
        j_reg         <= j_next;
        vj_reg        <= vj_next;
        res_value_reg <= res_value_next;
        drawn_value_reg <= drawn_value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            epoch_reg        <= '0;
            last_item_reg    <= 1'b0;
            exh_item_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            last_reg         <= 1'b0;
            exhausted_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            epoch_reg        <= epoch_next;
            last_item_reg    <= last_item_next;
            exh_item_reg     <= exh_item_next;
            result_valid_reg <= result_valid_next;
            last_reg         <= last_next;
            exhausted_reg    <= exhausted_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign drawn_value  = drawn_value_reg;
    assign last         = last_reg;
    assign exhausted    = exhausted_reg;

    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ((div_reg != '0) && (rem_reg < div_reg)))
        else $error("remainder not below divisor");

    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR) |-> (epoch_reg != '0))
        else $error("epoch zero outside clearing pass");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result loaded outside emit");

    a_exhausted_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && exhausted_reg) |-> ((drawn_value_reg == '0) && !last_reg))
        else $error("exhausted beat carries value or last");

endmodule

`default_nettype wire

@@ rtl/sample_without_replacement.sv @@
// sample_without_replacement: top level, configuration registers and the
// front, queue and back parts
// depends on swr_pkg, swr_front, swr_queue, swr_back
`default_nettype none

// Draws distinct values from low_bound .. low_bound + span - 1 with a sparse
// partial shuffle: each random word beat yields one result beat. For a draw
// the back part takes the draw from the queue, forms the bit-serial remainder
// of random_word by the remaining span (one bit a cycle), then works the slot
// table (read slot j, read slot i, write slot j) and loads the result
// register. An exhausted beat skips the remainder and the table and goes
// straight to the result register. The front part keeps the position itself
// and queues up to two classified beats, so the next word is taken while a
// draw is running and a finished result waits in its own register. Slot
// entries carry an epoch tag instead of per-slot written bits; ending a
// sample just advances the epoch. After reset, and again after every 255
// finished samples, a clearing pass sweeps the table, and random words are
// stalled for its duration (configuration writes are still taken). Registers:
// 0 low_bound, 1 span (clamped to RANGE_DEPTH), 2 sample_count; other indexes
// are ignored. Write them only while the block is idle.
module sample_without_replacement #(
    parameter int RANGE_DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [swr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [swr_pkg::WORD_W-1:0]           cfg_data,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [swr_pkg::WORD_W-1:0]           random_word,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [swr_pkg::WORD_W-1:0]    drawn_value,
    output logic                                 last,
    output logic                                 exhausted
);
    import swr_pkg::*;

    logic signed [WORD_W-1:0] low_bound_reg, low_bound_next;
    logic [SPAN_W-1:0]        span_reg, span_next;
    logic [SPAN_W-1:0]        sample_count_reg, sample_count_next;
    logic                     cfg_write;

    back_status_t             status;
    logic                     push_valid;
    logic                     push_ready;
    draw_item_t               push_item;
    logic                     pop_valid;
    logic                     pop_ready;
    draw_item_t               pop_item;

    // register writes are always accepted: cfg_ready is tied high
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        low_bound_next    = low_bound_reg;
        span_next         = span_reg;
        sample_count_next = sample_count_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_LOW_BOUND:    low_bound_next    = cfg_data;
                REG_SPAN:         span_next         = cfg_data[SPAN_W-1:0];
                REG_SAMPLE_COUNT: sample_count_next = cfg_data[SPAN_W-1:0];
                default:          ; // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_bound_reg    <= '0;
            span_reg         <= SPAN_W'(1024);
            sample_count_reg <= SPAN_W'(1024);
        end
        else
        begin
            low_bound_reg    <= low_bound_next;
            span_reg         <= span_next;
            sample_count_reg <= sample_count_next;
        end
    end

    // front: position tracking and classification of each word
    swr_front #(
        .RANGE_DEPTH (RANGE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .random_word  (random_word),
        .span         (span_reg),
        .sample_count (sample_count_reg),
        .status       (status),
        .push_ready   (push_ready),
        .push_valid   (push_valid),
        .push_item    (push_item)
    );

    // short queue lets the front keep taking words during a draw
    swr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // back: remainder, table update and result register
    swr_back #(
        .RANGE_DEPTH (RANGE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .low_bound    (low_bound_reg),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .drawn_value  (drawn_value),
        .last         (last),
        .exhausted    (exhausted)
    );

endmodule

`default_nettype wire
